>>> rtl/core/bsst_pkg.sv
// shared constants and types for the bounded set span tracker
package bsst_pkg;

    // default sizing
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    // fixed field widths
    localparam int CAP_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int GAP_OUT_W = 32;
    localparam int MG_W      = 33;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // running minimum gap before any gap exists
    localparam logic [MG_W-1:0] MG_NONE = {MG_W{1'b1}};

    // status codes
    localparam logic STATUS_STORED   = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // where the new key lands in the sorted row
    typedef struct packed {
        logic stored;
        logic has_pred;
        logic has_succ;
        logic at_front;
        logic at_end;
    } bsst_ins_t;

endpackage

>>> rtl/core/bsst_cell.sv
// one compare-and-shift cell of the sorted row
module bsst_cell #(
    parameter int VALUE_BITS = bsst_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [VALUE_BITS-1:0] key,
    input  logic [CNT_W-1:0]      held_count,
    input  logic [VALUE_BITS-1:0] left_val,
    input  logic                  left_gt,
    output logic [VALUE_BITS-1:0] val,
    output logic                  valid,
    output logic                  gt,
    output logic                  ins
);

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;

    // occupancy and ordering against the broadcast key
    assign valid = (CNT_W'(IDX) < held_count);
    assign gt    = !valid || (val_reg > key);
    assign ins   = gt && !left_gt;
    assign val   = val_reg;

    // take the key at the insertion point, take the neighbour's value above it
    always_comb begin
        val_next = val_reg;
        if (gt) begin
            val_next = left_gt ? left_val : key;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            val_reg <= val_next;
        end
    end

endmodule

>>> rtl/core/bsst_chain.sv
// row of sorted cells with neighbour selection for the inserted key
module bsst_chain #(
    parameter int MAX_ENTRIES = bsst_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = bsst_pkg::VALUE_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [VALUE_BITS-1:0] key,
    input  logic [CNT_W-1:0]      held_count,
    output logic [VALUE_BITS-1:0] pred,
    output logic [VALUE_BITS-1:0] succ,
    output logic [VALUE_BITS-1:0] front,
    output bsst_pkg::bsst_ins_t   ins_info
);

    logic [VALUE_BITS-1:0] vals   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] lvals  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valids;
    logic [MAX_ENTRIES-1:0] gts;
    logic [MAX_ENTRIES-1:0] lgts;
    logic [MAX_ENTRIES-1:0] inss;

    // neighbour links, the front cell sees nothing larger on its left
    assign lvals[0] = '0;
    assign lgts[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign lvals[g] = vals[g-1];
                assign lgts[g]  = gts[g-1];
            end
            bsst_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W),
                .IDX        (g)
            ) u_cell (
                .aclk       (aclk),
                .shift_en   (shift_en),
                .key        (key),
                .held_count (held_count),
                .left_val   (lvals[g]),
                .left_gt    (lgts[g]),
                .val        (vals[g]),
                .valid      (valids[g]),
                .gt         (gts[g]),
                .ins        (inss[g])
            );
        end
    endgenerate

    // and-or pick of the values either side of the insertion point
    always_comb begin
        pred = '0;
        succ = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (inss[i]) begin
                pred = pred | lvals[i];
            end
            if (inss[i] && valids[i]) begin
                succ = succ | vals[i];
            end
        end
    end

    assign front             = vals[0];
    assign ins_info.stored   = shift_en;
    assign ins_info.has_pred = !inss[0];
    assign ins_info.has_succ = |(inss & valids);
    assign ins_info.at_front = inss[0];
    assign ins_info.at_end   = !(|(inss & valids));

endmodule

>>> rtl/core/bsst_gap.sv
// gap arithmetic: running minimum gap update and span of the set
module bsst_gap #(
    parameter int VALUE_BITS = bsst_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0]          key,
    input  logic [VALUE_BITS-1:0]          pred,
    input  logic [VALUE_BITS-1:0]          succ,
    input  logic [VALUE_BITS-1:0]          lo,
    input  logic [VALUE_BITS-1:0]          hi,
    input  bsst_pkg::bsst_ins_t            ins_info,
    input  logic [bsst_pkg::MG_W-1:0]      min_gap,
    output logic [bsst_pkg::MG_W-1:0]      min_gap_next,
    output logic [bsst_pkg::GAP_OUT_W-1:0] span
);

    localparam int CW = (VALUE_BITS > bsst_pkg::MG_W) ? VALUE_BITS : bsst_pkg::MG_W;

    logic [VALUE_BITS-1:0] gap_left;
    logic [VALUE_BITS-1:0] gap_right;
    logic [VALUE_BITS-1:0] span_w;
    logic [CW-1:0]         gl_ext;
    logic [CW-1:0]         gr_ext;
    logic [CW-1:0]         mid_ext;
    logic [CW-1:0]         span_ext;
    logic [bsst_pkg::MG_W-1:0] mid;

    // exact gaps to both neighbours, keys are offset so no wrap occurs
    assign gap_left  = key - pred;
    assign gap_right = succ - key;
    assign gl_ext    = CW'(gap_left);
    assign gr_ext    = CW'(gap_right);

    // fold both gaps into the running minimum
    always_comb begin
        mid = min_gap;
        if (ins_info.stored && ins_info.has_pred && (gl_ext < CW'(min_gap))) begin
            mid = gl_ext[bsst_pkg::MG_W-1:0];
        end
        mid_ext      = CW'(mid);
        min_gap_next = mid;
        if (ins_info.stored && ins_info.has_succ && (gr_ext < mid_ext)) begin
            min_gap_next = gr_ext[bsst_pkg::MG_W-1:0];
        end
    end

    // largest minus smallest, low bits only
    assign span_w   = hi - lo;
    assign span_ext = CW'(span_w);
    assign span     = span_ext[bsst_pkg::GAP_OUT_W-1:0];

endmodule

>>> rtl/core/bounded_set_span_tracker_core.sv
// top level of the bounded sorted set span tracker
//
//  channel  | direction | payload
//  s_       | in        | tdata: value
//  m_       | out       | tuser: status, have_span; tdata: shortest_gap, longest_gap, entry_count
//  cfg_     | in        | cfg_wdata: capacity, written on cfg_we
//
// one transaction per cycle sustained while m_tready stays high; a result passes through the
// insertion stage register and the result register after its input transaction is accepted
// the insertion stage goes through the row of MAX_ENTRIES compare-and-shift cells,
// the gap stage updates the running minimum gap and forms the span
// m_tready low holds the result register and the gap stage, and s_tready drops
// once both are full; reset empties the set and sets capacity to its reset value
module bounded_set_span_tracker_core #(
    parameter int MAX_ENTRIES = bsst_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = bsst_pkg::VALUE_BITS_DEF,
    parameter int IN_TD_W     = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bsst_pkg::CAP_W-1:0]    cfg_wdata,  // capacity
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_TD_W-1:0]            s_tdata,    // value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [1:0]                    m_tuser,    // status, have_span
    output logic [71:0]                   m_tdata     // shortest_gap, longest_gap, entry_count
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CE_W  = (CNT_W > bsst_pkg::COUNT_W) ? CNT_W : bsst_pkg::COUNT_W;
    localparam int OUT_USED_W = 2 * bsst_pkg::GAP_OUT_W + bsst_pkg::COUNT_W;

    logic [bsst_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [VALUE_BITS-1:0]      max_reg;
    logic [bsst_pkg::MG_W-1:0]  min_gap_reg;

    logic                       b_valid_reg;
    logic [VALUE_BITS-1:0]      b_key_reg;
    logic [VALUE_BITS-1:0]      b_pred_reg;
    logic [VALUE_BITS-1:0]      b_succ_reg;
    logic [VALUE_BITS-1:0]      b_lo_reg;
    logic [VALUE_BITS-1:0]      b_hi_reg;
    bsst_pkg::bsst_ins_t        b_ins_reg;
    logic                       b_status_reg;
    logic [CNT_W-1:0]           b_count_reg;

    logic                       out_valid_reg;
    logic                       out_status_reg;
    logic                       out_span_reg;
    logic [bsst_pkg::GAP_OUT_W-1:0] out_short_reg;
    logic [bsst_pkg::GAP_OUT_W-1:0] out_long_reg;
    logic [bsst_pkg::COUNT_W-1:0]   out_count_reg;

    logic                       in_acc;
    logic                       b_go;
    logic                       full;
    logic                       store;
    logic [VALUE_BITS-1:0]      key;
    logic [VALUE_BITS-1:0]      pred;
    logic [VALUE_BITS-1:0]      succ;
    logic [VALUE_BITS-1:0]      front;
    bsst_pkg::bsst_ins_t        ins_info;
    logic [bsst_pkg::MG_W-1:0]  min_gap_next;
    logic [bsst_pkg::GAP_OUT_W-1:0] span;
    logic                       b_have_span;
    logic [CE_W-1:0]            b_count_ext;

    // handshakes
    assign b_go     = b_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !b_valid_reg || b_go;
    assign in_acc   = s_tvalid && s_tready;

    // offset binary key so unsigned order matches signed order
    assign key = s_tdata[VALUE_BITS-1:0] ^ {1'b1, {(VALUE_BITS-1){1'b0}}};

    // capacity check, limit saturates at the row length
    assign full  = (CE_W'(count_reg) >= CE_W'(cap_reg)) ||
                   (count_reg == CNT_W'(MAX_ENTRIES));
    assign store = in_acc && !full;

    bsst_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS),
        .CNT_W       (CNT_W)
    ) u_chain (
        .aclk        (aclk),
        .shift_en    (store),
        .key         (key),
        .held_count  (count_reg),
        .pred        (pred),
        .succ        (succ),
        .front       (front),
        .ins_info    (ins_info)
    );

    bsst_gap #(
        .VALUE_BITS   (VALUE_BITS)
    ) u_gap (
        .key          (b_key_reg),
        .pred         (b_pred_reg),
        .succ         (b_succ_reg),
        .lo           (b_lo_reg),
        .hi           (b_hi_reg),
        .ins_info     (b_ins_reg),
        .min_gap      (min_gap_reg),
        .min_gap_next (min_gap_next),
        .span         (span)
    );

    assign b_have_span = (b_count_reg >= CNT_W'(2));
    assign b_count_ext = CE_W'(b_count_reg);

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bsst_pkg::CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // insertion stage: count and the gap stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            if (store) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (in_acc) begin
                b_valid_reg <= 1'b1;
            end else if (b_go) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // insertion stage payload
    always_ff @(posedge aclk) begin
        if (store && ins_info.at_end) begin
            max_reg <= key;
        end
        if (in_acc) begin
            b_key_reg    <= key;
            b_pred_reg   <= pred;
            b_succ_reg   <= succ;
            b_ins_reg    <= ins_info;
            b_status_reg <= full ? bsst_pkg::STATUS_REJECTED : bsst_pkg::STATUS_STORED;
            b_count_reg  <= store ? count_reg + CNT_W'(1) : count_reg;
            b_lo_reg     <= (store && ins_info.at_front) ? key : front;
            b_hi_reg     <= (store && ins_info.at_end) ? key : max_reg;
        end
    end

    // gap stage: minimum gap state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gap_reg   <= bsst_pkg::MG_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (b_go) begin
                min_gap_reg   <= min_gap_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go) begin
            out_status_reg <= b_status_reg;
            out_span_reg   <= b_have_span;
            out_short_reg  <= b_have_span ? min_gap_next[bsst_pkg::GAP_OUT_W-1:0] : '0;
            out_long_reg   <= b_have_span ? span : '0;
            out_count_reg  <= b_count_ext[bsst_pkg::COUNT_W-1:0];
        end
    end

    // result transaction
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_span_reg, out_status_reg};
    assign m_tdata  = {{(72 - OUT_USED_W){1'b0}}, out_count_reg, out_long_reg, out_short_reg};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("held count beyond row length");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && full) |=> $stable(count_reg))
        else $error("rejected transaction changed the count");

    a_gap_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (min_gap_reg <= $past(min_gap_reg)))
        else $error("minimum gap grew");

    a_no_span_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_span_reg) |-> (out_short_reg == '0 && out_long_reg == '0))
        else $error("gaps reported without a span");

    a_stage_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> b_valid_reg)
        else $error("accepted transaction lost before the gap stage");

endmodule

>>> dv/testbench.sv
// self-checking bench for the bounded set span tracker core
`timescale 1ns / 100ps

module testbench;

    localparam int SET_DEPTH = bsst_pkg::MAX_ENTRIES_DEF;
    localparam int REPORT_LIMIT = 10;

    // one result transaction, as the block should present it
    typedef struct packed {
        logic                           status;
        logic                           have_span;
        logic [bsst_pkg::GAP_OUT_W-1:0] shortest_gap;
        logic [bsst_pkg::GAP_OUT_W-1:0] longest_gap;
        logic [bsst_pkg::COUNT_W-1:0]   entry_count;
    } span_report_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [bsst_pkg::CAP_W-1:0]   cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [31:0]                  s_tdata   = '0;   // value
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [1:0]                   m_tuser;          // status, have_span
    logic [71:0]                  m_tdata;          // shortest_gap, longest_gap, entry_count

    // values waiting to be sent, every value ever queued, results still owed
    logic [31:0]       value_q[$];
    logic [31:0]       offered[$];
    span_report_t      report_q[$];

    // shadow of the set: keys with the sign bit flipped, ascending
    logic [31:0]                 set_keys[0:SET_DEPTH-1];
    int                          set_size   = 0;
    logic [bsst_pkg::MG_W-1:0]   gap_floor  = bsst_pkg::MG_NONE;
    logic [bsst_pkg::CAP_W-1:0]  cap_shadow = bsst_pkg::CAP_RESET;

    int                fault_count = 0;
    int                send_wait   = 0;
    int                recv_wait   = 0;
    int                send_calm   = 0;
    int                recv_calm   = 0;

    bounded_set_span_tracker_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // clock
    always #10 aclk = ~aclk;

    // gap before the next transaction, with occasional stretches of none
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 60);
        return $urandom_range(0, 18);
    endfunction

    // offer one value to the shadow set and queue the result it must give
    function automatic void offer_to_set(input logic [31:0] value);
        logic [31:0]               key;
        logic [bsst_pkg::MG_W-1:0] diff;
        int                        lim;
        int                        slot;
        span_report_t              want;
        key  = value ^ 32'h8000_0000;
        lim  = (int'(cap_shadow) > SET_DEPTH) ? SET_DEPTH : int'(cap_shadow);
        want = '0;
        want.status = bsst_pkg::STATUS_STORED;
        if (set_size >= lim) begin
            want.status = bsst_pkg::STATUS_REJECTED;
        end else begin
            slot = 0;
            while (slot < set_size && set_keys[slot] <= key) slot++;
            for (int i = set_size; i > slot; i--) set_keys[i] = set_keys[i-1];
            set_keys[slot] = key;
            set_size++;
            // running minimum only looks at the new neighbours
            if (slot > 0) begin
                diff = {1'b0, key} - {1'b0, set_keys[slot-1]};
                if (diff < gap_floor) gap_floor = diff;
            end
            if (slot + 1 < set_size) begin
                diff = {1'b0, set_keys[slot+1]} - {1'b0, key};
                if (diff < gap_floor) gap_floor = diff;
            end
        end
        want.have_span = (set_size >= 2);
        if (want.have_span) begin
            want.shortest_gap = gap_floor[bsst_pkg::GAP_OUT_W-1:0];
            want.longest_gap  = set_keys[set_size-1] - set_keys[0];
        end
        want.entry_count = set_size[bsst_pkg::COUNT_W-1:0];
        report_q = {report_q, want};
    endfunction

    // random value: uniform, or close to or equal to an earlier one
    function automatic logic [31:0] random_value(input bit dup_ok);
        logic [31:0] base;
        logic [31:0] delta;
        int          pick;
        pick = $urandom_range(0, 9);
        if (offered.size() == 0 || pick < 5) return $urandom;
        base = offered[$urandom_range(0, offered.size() - 1)];
        if (pick == 9) return dup_ok ? base : $urandom;
        delta = ($urandom & ((32'h1 << $urandom_range(0, 29)) - 32'h1)) + 32'h1;
        return pick[0] ? base + delta : base - delta;
    endfunction

    task automatic queue_value(input logic [31:0] value);
        value_q = {value_q, value};
        offered = {offered, value};
    endtask

    // wait until nothing is queued, in flight or owed
    task automatic settle();
        while (value_q.size() != 0 || s_tvalid || report_q.size() != 0)
            @(posedge aclk);
    endtask

    // capacity write, only ever issued with the block idle
    task automatic set_capacity(input logic [bsst_pkg::CAP_W-1:0] cap);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        cap_shadow = cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input logic [bsst_pkg::CAP_W-1:0] cap, input int count,
                                input bit dup_ok);
        set_capacity(cap);
        for (int i = 0; i < count; i++) queue_value(random_value(dup_ok));
        settle();
    endtask

    task automatic report_fault(input string what, input span_report_t want,
                                input span_report_t seen);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t %s: exp st=%0b sp=%0b min=%h span=%h n=%0d,",
                     $time, what, want.status, want.have_span, want.shortest_gap,
                     want.longest_gap, want.entry_count,
                     " got st=%0b sp=%0b min=%h span=%h n=%0d",
                     seen.status, seen.have_span, seen.shortest_gap,
                     seen.longest_gap, seen.entry_count);
    endtask

    // input side: send queued values, predict on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) offer_to_set(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (value_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= value_q.pop_front();
                    send_wait = draw_gap(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: stall at random, check each accepted transaction
    always @(posedge aclk) begin
        span_report_t seen;
        span_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.status       = m_tuser[0];
                seen.have_span    = m_tuser[1];
                seen.shortest_gap = m_tdata[31:0];
                seen.longest_gap  = m_tdata[63:32];
                seen.entry_count  = m_tdata[70:64];
                if (report_q.size() == 0) begin
                    report_fault("result with none owed", '0, seen);
                end else begin
                    want = report_q.pop_front();
                    if (seen !== want) report_fault("wrong result", want, seen);
                end
                recv_wait = draw_gap(recv_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset capacity: field extremes and alternating bit patterns
        queue_value(32'h8000_0000);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h0000_0000);
        queue_value(32'h5555_5555);
        queue_value(32'hAAAA_AAAA);
        settle();

        // zero capacity rejects everything
        set_capacity(7'd0);
        queue_value(32'h8000_0000);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h1234_5678);
        queue_value(32'hFFFF_FFFF);
        settle();

        // capacity below the current count
        set_capacity(7'd3);
        queue_value(32'h0000_0001);
        queue_value(32'hFFFF_FFFF);
        settle();

        // room for four more, then full
        set_capacity(7'd9);
        queue_value(32'hC000_0000);
        queue_value(32'h3FFF_FFFF);
        queue_value(32'h2000_0000);
        queue_value(32'hE000_0000);
        queue_value(32'h0F0F_0F0F);
        settle();

        // random fill through several capacities, duplicates only late
        random_phase(7'd20, 150, 1'b0);
        random_phase(7'd45, 150, 1'b0);
        set_capacity(7'd64);
        queue_value(32'h5555_5555);
        settle();
        random_phase(7'd64, 150, 1'b1);
        random_phase(7'd127, 300, 1'b1);
        random_phase(7'd0, 100, 1'b1);
        random_phase(7'd65, 200, 1'b1);
        random_phase(7'd100, 300, 1'b1);

        repeat (8) @(posedge aclk);
        if (fault_count == 0 && report_q.size() == 0)
            $display("bounded_set_span_tracker_core: match");
        else
            $display("bounded_set_span_tracker_core: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("bounded_set_span_tracker_core: mismatch");
        $finish;
    end

endmodule
